/* rtl/actuator_flutter_rate_guard_defines.svh */
// ----------------------------------------------------------------------------
// Actuator flutter rate guard: assertion macros
// Shared property forms for the port checker of the guard.
// ----------------------------------------------------------------------------
`ifndef ACTUATOR_FLUTTER_RATE_GUARD_DEFINES_SVH
`define ACTUATOR_FLUTTER_RATE_GUARD_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define AFRG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define AFRG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/afrg_pkg.sv */
// ----------------------------------------------------------------------------
// Actuator flutter rate guard: package
// Types, codes and constants shared by the modules of the guard.
// ----------------------------------------------------------------------------
package afrg_pkg;

    localparam int MAX_OPS_DEF    = 16;
    localparam int GATE_COUNT_DEF = 8;
    localparam int GATE_IDX_W     = 3;
    localparam int TIME_W         = 32;
    localparam int IVL_W          = 20;
    localparam int POS_W          = 8;
    localparam int MASK_W         = 8;
    localparam int POSV_W         = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;

    localparam logic [3:0]        GATE_NONE        = 4'b1111;
    localparam logic [IVL_W-1:0]  MIN_INTERVAL_RST = 20'd1000;
    localparam logic [IVL_W-1:0]  WINDOW_RST       = 20'd60000;
    localparam logic [MASK_W-1:0] MASK_RST         = 8'hFF;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_OPEN   = 2'd1,
        OP_CLOSE  = 2'd2,
        OP_SELECT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_MOVED = 2'd1,
        ACT_LED   = 2'd2,
        ACT_DEFER = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        REG_MIN_INTERVAL = 3'd0,
        REG_WINDOW       = 3'd1,
        REG_CLOSED_MAX   = 3'd2,
        REG_SERVO_EN     = 3'd3,
        REG_LOW_POS      = 3'd4,
        REG_HIGH_POS     = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_GUARD,
        ST_WALK,
        ST_DECIDE,
        ST_SEL_OPEN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        CTX_SINGLE,
        CTX_SEL_CLOSE,
        CTX_SEL_OPEN,
        CTX_TICK
    } ctx_t;

    typedef enum logic [1:0] {
        DRV_CMD,
        DRV_CUR,
        DRV_SCAN
    } drv_src_t;

    typedef struct packed {
        logic [IVL_W-1:0]  min_interval;
        logic [IVL_W-1:0]  window;
        logic [MASK_W-1:0] closed_max;
        logic [MASK_W-1:0] servo_en;
        logic [POSV_W-1:0] low_pos;
        logic [POSV_W-1:0] high_pos;
    } cfg_t;

    typedef struct packed {
        logic                  load;
        logic                  drv_set;
        drv_src_t              drv_src;
        logic                  walk_clr;
        logic                  walk_rd;
        logic                  decide;
        logic                  set_cur_sel;
        logic                  finish;
        logic [GATE_IDX_W-1:0] scan_idx;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic gate_ok_oc;
        logic gate_ok_sel;
        logic gate_none;
        logic cur_valid;
        logic latch;
        logic scan_due;
    } sts_t;

    typedef struct packed {
        logic [3:0]       target;
        act_t             action;
        logic [POS_W-1:0] position;
        logic             led;
        logic             err;
        logic [3:0]       open;
    } res_t;

endpackage

/* rtl/afrg_ram.sv */
// ----------------------------------------------------------------------------
// Actuator flutter rate guard: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module afrg_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/afrg_cfg.sv */
// ----------------------------------------------------------------------------
// Actuator flutter rate guard: configuration registers
// Holds the interval, window, orientation, fitting and position registers.
// ----------------------------------------------------------------------------
module afrg_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [afrg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [afrg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output afrg_pkg::cfg_t                   cfg
);

    afrg_pkg::cfg_t cfg_reg;
    afrg_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (afrg_pkg::cfg_reg_t'(cfg_index))
                afrg_pkg::REG_MIN_INTERVAL:
                    cfg_next.min_interval = cfg_data[afrg_pkg::IVL_W-1:0];
                afrg_pkg::REG_WINDOW:
                    cfg_next.window = cfg_data[afrg_pkg::IVL_W-1:0];
                afrg_pkg::REG_CLOSED_MAX:
                    cfg_next.closed_max = cfg_data[afrg_pkg::MASK_W-1:0];
                afrg_pkg::REG_SERVO_EN:
                    cfg_next.servo_en = cfg_data[afrg_pkg::MASK_W-1:0];
                afrg_pkg::REG_LOW_POS:
                    cfg_next.low_pos = cfg_data[afrg_pkg::POSV_W-1:0];
                afrg_pkg::REG_HIGH_POS:
                    cfg_next.high_pos = cfg_data[afrg_pkg::POSV_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_interval <= afrg_pkg::MIN_INTERVAL_RST;
            cfg_reg.window       <= afrg_pkg::WINDOW_RST;
            cfg_reg.closed_max   <= afrg_pkg::MASK_RST;
            cfg_reg.servo_en     <= afrg_pkg::MASK_RST;
            cfg_reg.low_pos      <= '0;
            cfg_reg.high_pos     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/afrg_ctrl.sv */
// ----------------------------------------------------------------------------
// Actuator flutter rate guard: controller
// Sequences dispatch, tick scan, ring walk, guard decision and result flush.
// ----------------------------------------------------------------------------
module afrg_ctrl #(
    parameter int  MAX_OPS    = afrg_pkg::MAX_OPS_DEF,
    parameter int  GATE_COUNT = afrg_pkg::GATE_COUNT_DEF,
    localparam int AW         = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1,
    localparam int CW         = $clog2(MAX_OPS + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  afrg_pkg::sts_t sts,
    output afrg_pkg::cmd_t cmd,
    output logic [AW-1:0]  walk_addr
);

    afrg_pkg::state_t state_reg;
    afrg_pkg::state_t state_next;
    afrg_pkg::ctx_t   ctx_reg;
    afrg_pkg::ctx_t   ctx_next;
    logic [afrg_pkg::GATE_IDX_W-1:0] scan_reg;
    logic [afrg_pkg::GATE_IDX_W-1:0] scan_next;
    logic [CW-1:0]    walk_reg;
    logic [CW-1:0]    walk_next;
    logic             last_scan;

    assign last_scan = (32'(scan_reg) == GATE_COUNT - 1);
    assign busy      = (state_reg != afrg_pkg::ST_IDLE);
    assign walk_addr = walk_reg[AW-1:0];

    always_comb
    begin
        state_next   = state_reg;
        ctx_next     = ctx_reg;
        scan_next    = scan_reg;
        walk_next    = walk_reg;
        cmd          = '0;
        cmd.drv_src  = afrg_pkg::DRV_CMD;
        cmd.scan_idx = scan_reg;
        unique case (state_reg)
            afrg_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = afrg_pkg::ST_DISPATCH;
                end
            end
            afrg_pkg::ST_DISPATCH:
            begin
                unique case (sts.op)
                    afrg_pkg::OP_TICK:
                    begin
                        if (sts.latch)
                        begin
                            state_next = afrg_pkg::ST_FINISH;
                        end
                        else
                        begin
                            scan_next  = '0;
                            state_next = afrg_pkg::ST_SCAN;
                        end
                    end
                    afrg_pkg::OP_OPEN, afrg_pkg::OP_CLOSE:
                    begin
                        if (sts.gate_ok_oc)
                        begin
                            cmd.drv_set = 1'b1;
                            cmd.drv_src = afrg_pkg::DRV_CMD;
                            ctx_next    = afrg_pkg::CTX_SINGLE;
                            state_next  = afrg_pkg::ST_GUARD;
                        end
                        else
                        begin
                            state_next = afrg_pkg::ST_FINISH;
                        end
                    end
                    afrg_pkg::OP_SELECT:
                    begin
                        if (!sts.gate_ok_sel)
                        begin
                            state_next = afrg_pkg::ST_FINISH;
                        end
                        else if (sts.cur_valid)
                        begin
                            cmd.drv_set = 1'b1;
                            cmd.drv_src = afrg_pkg::DRV_CUR;
                            ctx_next    = afrg_pkg::CTX_SEL_CLOSE;
                            state_next  = afrg_pkg::ST_GUARD;
                        end
                        else
                        begin
                            state_next = afrg_pkg::ST_SEL_OPEN;
                        end
                    end
                endcase
            end
            afrg_pkg::ST_SCAN:
            begin
                if (sts.scan_due)
                begin
                    cmd.drv_set = 1'b1;
                    cmd.drv_src = afrg_pkg::DRV_SCAN;
                    ctx_next    = afrg_pkg::CTX_TICK;
                    state_next  = afrg_pkg::ST_GUARD;
                end
                else if (last_scan)
                begin
                    state_next = afrg_pkg::ST_FINISH;
                end
                else
                begin
                    scan_next = scan_reg + 3'd1;
                end
            end
            afrg_pkg::ST_GUARD:
            begin
                cmd.walk_clr = 1'b1;
                walk_next    = '0;
                if (sts.latch)
                begin
                    state_next = afrg_pkg::ST_DECIDE;
                end
                else
                begin
                    state_next = afrg_pkg::ST_WALK;
                end
            end
            afrg_pkg::ST_WALK:
            begin
                cmd.walk_rd = (walk_reg < CW'(MAX_OPS));
                if (walk_reg == CW'(MAX_OPS))
                begin
                    state_next = afrg_pkg::ST_DECIDE;
                end
                else
                begin
                    walk_next = walk_reg + CW'(1);
                end
            end
            afrg_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                unique case (ctx_reg)
                    afrg_pkg::CTX_SINGLE, afrg_pkg::CTX_SEL_OPEN:
                        state_next = afrg_pkg::ST_FINISH;
                    afrg_pkg::CTX_SEL_CLOSE:
                        state_next = afrg_pkg::ST_SEL_OPEN;
                    afrg_pkg::CTX_TICK:
                    begin
                        if (last_scan)
                        begin
                            state_next = afrg_pkg::ST_FINISH;
                        end
                        else
                        begin
                            scan_next  = scan_reg + 3'd1;
                            state_next = afrg_pkg::ST_SCAN;
                        end
                    end
                endcase
            end
            afrg_pkg::ST_SEL_OPEN:
            begin
                cmd.set_cur_sel = 1'b1;
                if (sts.gate_none)
                begin
                    state_next = afrg_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.drv_set = 1'b1;
                    cmd.drv_src = afrg_pkg::DRV_CMD;
                    ctx_next    = afrg_pkg::CTX_SEL_OPEN;
                    state_next  = afrg_pkg::ST_GUARD;
                end
            end
            afrg_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = afrg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= afrg_pkg::ST_IDLE;
            ctx_reg   <= afrg_pkg::CTX_SINGLE;
            scan_reg  <= '0;
            walk_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
            scan_reg  <= scan_next;
            walk_reg  <= walk_next;
        end
    end

endmodule

/* rtl/afrg_dp.sv */
// ----------------------------------------------------------------------------
// Actuator flutter rate guard: datapath
// Gate state, move-time ring, guard decision and the result registers.
// ----------------------------------------------------------------------------
module afrg_dp #(
    parameter int  MAX_OPS    = afrg_pkg::MAX_OPS_DEF,
    parameter int  GATE_COUNT = afrg_pkg::GATE_COUNT_DEF,
    localparam int AW         = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1,
    localparam int CW         = $clog2(MAX_OPS + 1),
    localparam int GW         = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    op,
    input  logic [3:0]                    gate,
    input  logic [afrg_pkg::TIME_W-1:0]   now_ms,
    input  afrg_pkg::cfg_t                cfg,
    input  afrg_pkg::cmd_t                cmd,
    input  logic [AW-1:0]                 walk_addr,
    output afrg_pkg::sts_t                sts,
    output afrg_pkg::res_t                res,
    output logic                          res_strobe,
    output logic                          res_last
);

    localparam int TW = afrg_pkg::TIME_W;

    afrg_pkg::op_t   op_reg;
    logic [3:0]      gate_reg;
    logic [TW-1:0]   now_reg;
    logic [TW-1:0]   since_reg;
    logic [3:0]      cur_open_reg;
    logic            latch_reg;
    logic            pend_reg      [GATE_COUNT];
    logic            pend_open_reg [GATE_COUNT];
    logic [TW-1:0]   last_move_reg [GATE_COUNT];
    logic [afrg_pkg::GATE_IDX_W-1:0] drv_gate_reg;
    logic            drv_open_reg;
    logic [CW-1:0]   cnt_reg;
    logic            acc_en_reg;
    logic            ent_valid_reg;
    logic            ring_valid_reg [MAX_OPS];
    logic [AW-1:0]   slot_reg;
    logic            buf_valid_reg;
    afrg_pkg::res_t  buf_reg;
    afrg_pkg::res_t  out_reg;
    logic            out_last_reg;
    logic            strobe_reg;

    logic [TW-1:0]   ring_rdata;
    logic            ring_we;
    logic [GW-1:0]   dg;
    logic [GW-1:0]   sg;
    logic [TW-1:0]   min_ext;
    logic            too_soon;
    logic            over;
    logic            refuse;
    logic            latch_set;
    logic            use_low;
    logic            servo;
    logic [afrg_pkg::POS_W-1:0] pos;
    afrg_pkg::res_t  new_res;
    afrg_pkg::res_t  none_res;

    assign dg      = drv_gate_reg[GW-1:0];
    assign sg      = cmd.scan_idx[GW-1:0];
    assign min_ext = {{(TW - afrg_pkg::IVL_W){1'b0}}, cfg.min_interval};

    always_comb
    begin
        sts.op          = op_reg;
        sts.gate_ok_oc  = !gate_reg[3] && (32'(gate_reg[2:0]) < GATE_COUNT);
        sts.gate_ok_sel = sts.gate_ok_oc || (gate_reg == afrg_pkg::GATE_NONE);
        sts.gate_none   = (gate_reg == afrg_pkg::GATE_NONE);
        sts.cur_valid   = !cur_open_reg[3];
        sts.latch       = latch_reg;
        sts.scan_due    = pend_reg[sg] && !((now_reg - last_move_reg[sg]) < min_ext);
    end

    always_comb
    begin
        too_soon  = (now_reg - last_move_reg[dg]) < min_ext;
        over      = (cnt_reg >= CW'(MAX_OPS));
        refuse    = latch_reg || over || too_soon;
        latch_set = !latch_reg && over;
        use_low   = drv_open_reg ? cfg.closed_max[drv_gate_reg]
                                 : !cfg.closed_max[drv_gate_reg];
        servo     = cfg.servo_en[drv_gate_reg];
        pos       = use_low ? cfg.low_pos[{drv_gate_reg, 3'b000} +: afrg_pkg::POS_W]
                            : cfg.high_pos[{drv_gate_reg, 3'b000} +: afrg_pkg::POS_W];

        new_res.target = {1'b0, drv_gate_reg};
        if (refuse)
        begin
            new_res.action = afrg_pkg::ACT_DEFER;
        end
        else if (servo)
        begin
            new_res.action = afrg_pkg::ACT_MOVED;
        end
        else
        begin
            new_res.action = afrg_pkg::ACT_LED;
        end
        new_res.position = (!refuse && servo) ? pos : '0;
        new_res.led      = !refuse && drv_open_reg;
        new_res.err      = latch_reg || latch_set;
        new_res.open     = (!refuse && drv_open_reg) ? {1'b0, drv_gate_reg} : cur_open_reg;

        none_res.target   = afrg_pkg::GATE_NONE;
        none_res.action   = afrg_pkg::ACT_NONE;
        none_res.position = '0;
        none_res.led      = 1'b0;
        none_res.err      = latch_reg;
        none_res.open     = cur_open_reg;

        ring_we = cmd.decide && !refuse && servo;
    end

    afrg_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_OPS)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (slot_reg),
        .wdata (now_reg),
        .re    (cmd.walk_rd),
        .raddr (walk_addr),
        .rdata (ring_rdata)
    );

    // Item capture, drive selection and result registers; payload only.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= afrg_pkg::op_t'(op);
            gate_reg  <= gate;
            now_reg   <= now_ms;
            since_reg <= now_ms - {{(TW - afrg_pkg::IVL_W){1'b0}}, cfg.window};
        end
        if (cmd.drv_set)
        begin
            case (cmd.drv_src)
                afrg_pkg::DRV_CUR:
                begin
                    drv_gate_reg <= cur_open_reg[2:0];
                    drv_open_reg <= 1'b0;
                end
                afrg_pkg::DRV_SCAN:
                begin
                    drv_gate_reg <= cmd.scan_idx;
                    drv_open_reg <= pend_open_reg[sg];
                end
                default:
                begin
                    drv_gate_reg <= gate_reg[2:0];
                    drv_open_reg <= (op_reg != afrg_pkg::OP_CLOSE);
                end
            endcase
        end
        if (cmd.decide)
        begin
            buf_reg <= new_res;
        end
        if (cmd.decide)
        begin
            out_reg      <= buf_reg;
            out_last_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_reg      <= buf_valid_reg ? buf_reg : none_res;
            out_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_open_reg  <= afrg_pkg::GATE_NONE;
            latch_reg     <= 1'b0;
            slot_reg      <= '0;
            cnt_reg       <= '0;
            acc_en_reg    <= 1'b0;
            ent_valid_reg <= 1'b0;
            buf_valid_reg <= 1'b0;
            strobe_reg    <= 1'b0;
            for (int i = 0; i < GATE_COUNT; i++)
            begin
                pend_reg[i]      <= 1'b0;
                pend_open_reg[i] <= 1'b0;
                last_move_reg[i] <= '0;
            end
            for (int k = 0; k < MAX_OPS; k++)
            begin
                ring_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            acc_en_reg    <= cmd.walk_rd;
            ent_valid_reg <= cmd.walk_rd && ring_valid_reg[walk_addr];
            if (cmd.walk_clr)
            begin
                cnt_reg <= '0;
            end
            else if (acc_en_reg && ent_valid_reg && (ring_rdata > since_reg))
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end

            if (cmd.drv_set && (cmd.drv_src == afrg_pkg::DRV_SCAN))
            begin
                pend_reg[sg] <= 1'b0;
            end

            if (cmd.set_cur_sel)
            begin
                cur_open_reg <= gate_reg;
            end

            if (cmd.decide)
            begin
                if (refuse)
                begin
                    pend_reg[dg]      <= 1'b1;
                    pend_open_reg[dg] <= drv_open_reg;
                end
                if (latch_set)
                begin
                    latch_reg <= 1'b1;
                end
                if (!refuse && drv_open_reg)
                begin
                    cur_open_reg <= {1'b0, drv_gate_reg};
                end
                if (ring_we)
                begin
                    last_move_reg[dg]        <= now_reg;
                    ring_valid_reg[slot_reg] <= 1'b1;
                    slot_reg <= (slot_reg == AW'(MAX_OPS - 1)) ? '0 : slot_reg + AW'(1);
                end
            end

            // A result waits in the buffer until the next one or the end of
            // the item shows whether it is the final one.
            if (cmd.decide)
            begin
                strobe_reg    <= buf_valid_reg;
                buf_valid_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                strobe_reg    <= 1'b1;
                buf_valid_reg <= 1'b0;
            end
            else
            begin
                strobe_reg <= 1'b0;
            end
        end
    end

    assign res        = out_reg;
    assign res_strobe = strobe_reg;
    assign res_last   = out_last_reg;

endmodule

/* rtl/actuator_flutter_rate_guard.sv */
// ----------------------------------------------------------------------------
// Actuator flutter rate guard: top level
// Rate and flutter guard for up to eight gate actuators.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; op, gate and now_ms
// are sampled on that edge. Busy stays high until the command has been fully
// worked off, and no new command is taken meanwhile.
// Each result appears for one cycle with strobe high; last marks the final
// result of a command. The receiver cannot stall: every strobe is a transfer.
// Every open or close that reaches the guard walks the move-time ring, one
// entry per cycle through its single read port; with the error latch set the
// walk is skipped. Unless the error latch is set, a tick scans the gates and
// retries each deferred gate that is due.
// Configuration writes use their own channel; cfg_ready is always high and
// writes are to be made only while busy is low.
// Reset clears all gate state, the ring and the error latch, records no gate
// as open and loads the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module actuator_flutter_rate_guard #(
    parameter int MAX_OPS    = afrg_pkg::MAX_OPS_DEF,
    parameter int GATE_COUNT = afrg_pkg::GATE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      op,
    input  logic signed [3:0]               gate,
    input  logic [afrg_pkg::TIME_W-1:0]     now_ms,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [afrg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [afrg_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            strobe,
    output logic signed [3:0]               target_gate,
    output logic [1:0]                      action,
    output logic [afrg_pkg::POS_W-1:0]      position,
    output logic                            led_on,
    output logic                            error_latched,
    output logic signed [3:0]               open_gate,
    output logic                            last
);

    localparam int AW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;

    afrg_pkg::cfg_t cfg;
    afrg_pkg::cmd_t cmd;
    afrg_pkg::sts_t sts;
    afrg_pkg::res_t res;
    logic [AW-1:0]  walk_addr;

    afrg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    afrg_ctrl #(
        .MAX_OPS    (MAX_OPS),
        .GATE_COUNT (GATE_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sts       (sts),
        .cmd       (cmd),
        .walk_addr (walk_addr)
    );

    afrg_dp #(
        .MAX_OPS    (MAX_OPS),
        .GATE_COUNT (GATE_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .gate       (gate),
        .now_ms     (now_ms),
        .cfg        (cfg),
        .cmd        (cmd),
        .walk_addr  (walk_addr),
        .sts        (sts),
        .res        (res),
        .res_strobe (strobe),
        .res_last   (last)
    );

    assign target_gate   = res.target;
    assign action        = res.action;
    assign position      = res.position;
    assign led_on        = res.led;
    assign error_latched = res.err;
    assign open_gate     = res.open;

endmodule

/* rtl/afrg_checker.sv */
// ----------------------------------------------------------------------------
// Actuator flutter rate guard: port checker
// Checks command and result sequencing as seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "actuator_flutter_rate_guard_defines.svh"

module afrg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic [3:0] target_gate,
    input logic [1:0] action,
    input logic       last
);

    `AFRG_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "command taken but busy low")
    `AFRG_ASSERT_IMP(a_mid_result, clk, rst_n, strobe && !last, busy, "non-final result while idle")
    `AFRG_ASSERT_IMP(a_final_idle, clk, rst_n, strobe && last, !busy, "final result while busy")
    `AFRG_ASSERT_IMP(a_done_final, clk, rst_n, $fell(busy), strobe && last, "command ended without final result")
    `AFRG_ASSERT_IMP(a_none_alone, clk, rst_n, strobe && (action == afrg_pkg::ACT_NONE), last && (target_gate == afrg_pkg::GATE_NONE), "nothing result not alone")

endmodule

bind actuator_flutter_rate_guard afrg_checker u_afrg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .strobe      (strobe),
    .target_gate (target_gate),
    .action      (action),
    .last        (last)
);
